// ===== rtl/core/spim_pkg.sv =====
package spim_pkg;

    localparam int DATA_W             = 16;
    localparam int FIFO_DEPTH_DEF     = 8;
    localparam int MAX_FRAME_BITS_DEF = 16;
    localparam int MIN_FRAME_BITS     = 4;

    localparam int FUNC_W      = 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int TDIV_W      = 16;
    localparam int STATUS_W    = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_STATUS = 2'd3
    } t_func;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_BITS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POLARITY   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRESCALE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE     = 3'd5;

    localparam logic [3:0] FRAME_BITS_RST = 4'd7;
    localparam logic [7:0] PRESCALE_RST   = 8'd2;
    localparam logic [7:0] PRESCALE_MASK  = 8'hFE;

    // Status bit positions.
    localparam int ST_TFE = 0;
    localparam int ST_TNF = 1;
    localparam int ST_RNE = 2;
    localparam int ST_RFF = 3;
    localparam int ST_BSY = 4;

endpackage

// ===== rtl/core/spim_fifo.sv =====
module spim_fifo #(
    parameter int DEPTH = spim_pkg::FIFO_DEPTH_DEF,
    parameter int WIDTH = spim_pkg::DATA_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic                       i_pop,
    input  logic [WIDTH-1:0]           i_wdata,
    output logic [WIDTH-1:0]           o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    // Callers never push into a full queue or pop an empty one.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == PTR_W'(DEPTH-1)) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == PTR_W'(DEPTH-1)) ? '0 : r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rdata = r_mem[r_head];
    assign o_count = r_count;

endmodule

// ===== rtl/core/spi_master_with_fifos.sv =====
// SPI master with 8-frame transmit and receive queues. Every input transaction is one
// operation chosen by tuser: a peripheral clock tick (0), a data write (1), a data read
// (2) or a status read (3); each produces exactly one output transaction carrying the
// read value, the status flags and the sclk/mosi levels after the operation. The whole
// effect of an operation is computed in a single pass of logic and is captured in the
// output register as the input transaction is accepted. The input is ready
// whenever that register is empty or is being drained in the same cycle, so one
// operation per cycle goes through while m_axis_tready stays high, and the input
// stalls for as long as a result waits. One serial bit lasts
// 2 * (prescale/2) * (rate+1) ticks, frames of 4..16 bits go out MSB first, and the
// configuration port should only be written while no transaction is in flight.
module spi_master_with_fifos #(
    parameter int FIFO_DEPTH     = spim_pkg::FIFO_DEPTH_DEF,
    parameter int MAX_FRAME_BITS = spim_pkg::MAX_FRAME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [spim_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [spim_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] write_data, [16] miso_in, [23:17] zero
    input  logic [spim_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [spim_pkg::FUNC_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] read_value, [20:16] status_bits, [21] sclk_out, [22] mosi_out, [23] zero
    output logic [spim_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int DATA_W = spim_pkg::DATA_W;
    localparam int CNT_W  = $clog2(FIFO_DEPTH+1);
    localparam int BI_W   = $clog2(MAX_FRAME_BITS+1);
    localparam int IDX_W  = $clog2(MAX_FRAME_BITS);
    localparam int TDIV_W = spim_pkg::TDIV_W;

    // Configuration.
    logic [3:0] r_fbm;
    logic       r_pol;
    logic       r_pha;
    logic [7:0] r_rate;
    logic [7:0] r_presc;
    logic       r_en;

    // Serial engine.
    logic [MAX_FRAME_BITS-1:0] r_so, n_so;
    logic [MAX_FRAME_BITS-1:0] r_si, n_si;
    logic [BI_W-1:0]           r_bi, n_bi;
    logic [TDIV_W-1:0]         r_td, n_td;
    logic                      r_cl, n_cl;
    logic                      r_busy, n_busy;

    logic                            r_out_valid;
    logic [spim_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                  accept;
    spim_pkg::t_func       func;
    logic [DATA_W-1:0]     wdata;
    logic                  miso;

    logic                  tx_push, tx_pop, rx_push, rx_pop;
    logic [DATA_W-1:0]     tx_rdata, rx_rdata, rx_wdata;
    logic [CNT_W-1:0]      tx_cnt, rx_cnt, tx_cnt_n, rx_cnt_n;

    logic [4:0]                fb_sum;
    logic [BI_W-1:0]           frame_n;
    logic [MAX_FRAME_BITS-1:0] frame_mask;
    logic [7:0]                presc_eff;
    logic [TDIV_W-1:0]         half;
    logic                      first_level;
    logic [MAX_FRAME_BITS-1:0] si_fin;
    logic [BI_W-1:0]           bi_dec;
    logic [DATA_W-1:0]         rd_val;
    logic [spim_pkg::STATUS_W-1:0] status;
    logic [spim_pkg::STATUS_W-1:0] status_cur;
    logic                      mosi;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign func          = spim_pkg::t_func'(s_axis_tuser);
    assign wdata         = s_axis_tdata[DATA_W-1:0];
    assign miso          = s_axis_tdata[DATA_W];

    spim_fifo #(.DEPTH(FIFO_DEPTH), .WIDTH(DATA_W)) u_tx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tx_push),
        .i_pop   (tx_pop),
        .i_wdata (wdata),
        .o_rdata (tx_rdata),
        .o_count (tx_cnt)
    );

    spim_fifo #(.DEPTH(FIFO_DEPTH), .WIDTH(DATA_W)) u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rx_push),
        .i_pop   (rx_pop),
        .i_wdata (rx_wdata),
        .o_rdata (rx_rdata),
        .o_count (rx_cnt)
    );

    // Frame length, clamped to the supported range.
    assign fb_sum = {1'b0, r_fbm} + 5'd1;
    always_comb begin
        if (r_fbm < 4'd3) begin
            frame_n = BI_W'(spim_pkg::MIN_FRAME_BITS);
        end else if (32'(fb_sum) > MAX_FRAME_BITS) begin
            frame_n = BI_W'(MAX_FRAME_BITS);
        end else begin
            frame_n = BI_W'(fb_sum);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_FRAME_BITS; i++) begin
            frame_mask[i] = (32'(frame_n) > i);
        end
    end

    assign presc_eff   = (r_presc == 8'd0) ? 8'd2 : r_presc;
    assign half        = TDIV_W'(presc_eff[7:1] * ({1'b0, r_rate} + 9'd1));
    assign first_level = r_pol ^ r_pha;

    // Status before the operation, returned by a status read.
    always_comb begin
        status_cur                   = '0;
        status_cur[spim_pkg::ST_TFE] = (tx_cnt == '0);
        status_cur[spim_pkg::ST_TNF] = (tx_cnt < CNT_W'(FIFO_DEPTH));
        status_cur[spim_pkg::ST_RNE] = (rx_cnt != '0);
        status_cur[spim_pkg::ST_RFF] = (rx_cnt >= CNT_W'(FIFO_DEPTH));
        status_cur[spim_pkg::ST_BSY] = r_busy || (r_en && tx_cnt != '0);
    end

    always_comb begin
        n_so     = r_so;
        n_si     = r_si;
        n_bi     = r_bi;
        n_td     = r_td;
        n_cl     = r_cl;
        n_busy   = r_busy;
        tx_push  = 1'b0;
        tx_pop   = 1'b0;
        rx_push  = 1'b0;
        rx_pop   = 1'b0;
        rx_wdata = '0;
        rd_val   = '0;
        si_fin   = r_si;
        bi_dec   = r_bi;

        if (accept) begin
            case (func)
                spim_pkg::FUNC_TICK: begin
                    if (r_en) begin
                        if (r_busy) begin
                            if (r_td >= half) begin
                                n_td = TDIV_W'(1);
                                if (r_cl == first_level) begin
                                    // Leading edge of the bit.
                                    n_cl = ~r_cl;
                                    if (!r_pha) begin
                                        n_si = {r_si[MAX_FRAME_BITS-2:0], miso};
                                    end
                                end else begin
                                    // Trailing edge ends the bit.
                                    if (r_pha) begin
                                        si_fin = {r_si[MAX_FRAME_BITS-2:0], miso};
                                    end
                                    n_si = si_fin;
                                    n_so = (r_so << 1) & frame_mask;
                                    if (r_bi != '0) begin
                                        bi_dec = r_bi - 1'b1;
                                    end
                                    n_bi = bi_dec;
                                    if (bi_dec == '0) begin
                                        if (rx_cnt < CNT_W'(FIFO_DEPTH)) begin
                                            rx_push  = 1'b1;
                                            rx_wdata = DATA_W'(si_fin & frame_mask);
                                        end
                                        n_busy = 1'b0;
                                        n_si   = '0;
                                        n_td   = '0;
                                        n_cl   = r_pol;
                                    end else begin
                                        n_cl = first_level;
                                    end
                                end
                            end else begin
                                n_td = r_td + 1'b1;
                            end
                        end
                        // A new frame may load in the same tick the previous one ends.
                        if (!n_busy && tx_cnt != '0) begin
                            tx_pop = 1'b1;
                            n_so   = MAX_FRAME_BITS'(tx_rdata) & frame_mask;
                            n_si   = '0;
                            n_bi   = frame_n;
                            n_td   = TDIV_W'(1);
                            n_busy = 1'b1;
                            n_cl   = first_level;
                        end
                    end
                end
                spim_pkg::FUNC_WRITE: begin
                    if (tx_cnt < CNT_W'(FIFO_DEPTH)) begin
                        tx_push = 1'b1;
                    end
                end
                spim_pkg::FUNC_READ: begin
                    if (rx_cnt != '0) begin
                        rx_pop = 1'b1;
                        rd_val = rx_rdata;
                    end
                end
                default: begin
                    rd_val = DATA_W'(status_cur);
                end
            endcase
        end
    end

    assign tx_cnt_n = tx_cnt + CNT_W'(tx_push) - CNT_W'(tx_pop);
    assign rx_cnt_n = rx_cnt + CNT_W'(rx_push) - CNT_W'(rx_pop);

    always_comb begin
        status                   = '0;
        status[spim_pkg::ST_TFE] = (tx_cnt_n == '0);
        status[spim_pkg::ST_TNF] = (tx_cnt_n < CNT_W'(FIFO_DEPTH));
        status[spim_pkg::ST_RNE] = (rx_cnt_n != '0);
        status[spim_pkg::ST_RFF] = (rx_cnt_n >= CNT_W'(FIFO_DEPTH));
        status[spim_pkg::ST_BSY] = n_busy || (r_en && tx_cnt_n != '0);
    end

    assign mosi = n_busy ? n_so[IDX_W'(frame_n - 1'b1)] : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fbm   <= spim_pkg::FRAME_BITS_RST;
            r_pol   <= 1'b0;
            r_pha   <= 1'b0;
            r_rate  <= '0;
            r_presc <= spim_pkg::PRESCALE_RST;
            r_en    <= 1'b0;
            r_so    <= '0;
            r_si    <= '0;
            r_bi    <= '0;
            r_td    <= '0;
            r_cl    <= 1'b0;
            r_busy  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                spim_pkg::CFG_FRAME_BITS: r_fbm <= i_cfg_wdata[3:0];
                spim_pkg::CFG_POLARITY: begin
                    r_pol <= i_cfg_wdata[0];
                    if (!r_busy) begin
                        r_cl <= i_cfg_wdata[0];
                    end
                end
                spim_pkg::CFG_PHASE:    r_pha   <= i_cfg_wdata[0];
                spim_pkg::CFG_RATE:     r_rate  <= i_cfg_wdata;
                spim_pkg::CFG_PRESCALE: r_presc <= i_cfg_wdata & spim_pkg::PRESCALE_MASK;
                spim_pkg::CFG_ENABLE: begin
                    r_en <= i_cfg_wdata[0];
                    // Disabling drops the frame in flight; the queues are kept.
                    if (!i_cfg_wdata[0]) begin
                        r_busy <= 1'b0;
                        r_bi   <= '0;
                        r_td   <= '0;
                        r_so   <= '0;
                        r_si   <= '0;
                        r_cl   <= r_pol;
                    end
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            r_so   <= n_so;
            r_si   <= n_si;
            r_bi   <= n_bi;
            r_td   <= n_td;
            r_cl   <= n_cl;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {1'b0, mosi, n_cl, status, rd_val};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
